/* rtl/core/isbn_pkg.sv */
// Shared constants and helpers for the ISBN-13 check digit validator.
// No dependencies; imported by every module under rtl/core.
package isbn_pkg;

    // Widths of the value path
    localparam int VAL_W      = 44;                  // binary ISBN width
    localparam int DIG_N      = 14;                  // decimal digits covering 2^44-1
    localparam int BCD_W      = 4 * DIG_N;           // packed BCD width
    localparam int STEP_BITS  = 4;                   // shift-add-3 steps per stage
    localparam int DBL_STAGES = VAL_W / STEP_BITS;   // number of conversion stages
    localparam int SUM_W      = 8;                   // weighted sum, max 216
    localparam int DIGIT_W    = 4;

    // Pipeline positions: input stage, conversion stages, sum stage, output stage
    localparam int SUM_POS = DBL_STAGES + 1;
    localparam int OUT_POS = DBL_STAGES + 2;
    localparam int NPOS    = DBL_STAGES + 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd1;

    localparam logic [VAL_W-1:0] LOWER_RESET = 44'd9780000000000;
    localparam logic [VAL_W-1:0] UPPER_RESET = 44'd9799999999999;

    // sum mod 10 through a reciprocal: floor(x * 205 / 2048) == floor(x / 10)
    // for every x up to 1028, which covers the 8-bit sum.
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 11;

    function automatic logic [DIGIT_W-1:0] check_digit(input logic [SUM_W-1:0] sum);
        logic [15:0]        prod;
        logic [4:0]         quot;
        logic [SUM_W-1:0]   qx10;
        logic [SUM_W-1:0]   rem;
        logic [DIGIT_W-1:0] res;
        prod = 16'(sum) * 16'(RECIP_MUL);
        quot = prod[RECIP_SHIFT +: 5];
        qx10 = SUM_W'({quot, 3'b000}) + SUM_W'({quot, 1'b0});
        rem  = sum - qx10;
        if (rem[DIGIT_W-1:0] == '0)
            res = '0;
        else
            res = DIGIT_W'(10) - rem[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

/* rtl/core/isbn_dbl_step.sv */
// One conversion stage: STEP_BITS shift-add-3 steps of binary to BCD.
// Depends on isbn_pkg.
module isbn_dbl_step
    import isbn_pkg::*;
(
    input  logic [BCD_W-1:0]     bcd_in,
    input  logic [STEP_BITS-1:0] bits_in,
    output logic [BCD_W-1:0]     bcd_out
);

    logic [BCD_W-1:0] bcd;

    // Per step: bump every digit of five or more by three, then shift in one bit
    always_comb
    begin
        bcd = bcd_in;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < DIG_N; d++)
            begin
                if (bcd[4*d +: 4] >= 4'd5)
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
            bcd = {bcd[BCD_W-2:0], bits_in[STEP_BITS-1-s]};
        end
        bcd_out = bcd;
    end

endmodule

/* rtl/core/isbn13_check_digit_validator.sv */
// Top level of the ISBN-13 check digit validator: range check, binary to BCD
// pipeline, weighted digit sum and check digit. Depends on isbn_pkg, isbn_dbl_step.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, isbn_value            | item in
//  out     | out_valid, out_ready, in_range, is_valid,  | item out
//          | weighted_sum, expected_digit, accepted_isbn|
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
// One item per cycle sustained while out_ready stays high. The pipeline holds
// the input register, the 11 binary-to-BCD stages (4 shift-add-3 steps each),
// the digit-sum stage and the output register.
// Every stage holds its item while the stage after it is full and stalled;
// bubbles are squeezed out. Reset clears all valid bits and restores both bounds.
// cfg_ready is always high.
module isbn13_check_digit_validator
    import isbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VAL_W-1:0]     isbn_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 in_range,
    output logic                 is_valid,
    output logic [SUM_W-1:0]     weighted_sum,
    output logic [DIGIT_W-1:0]   expected_digit,
    output logic [VAL_W-1:0]     accepted_isbn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    logic [VAL_W-1:0]   lower_bound_reg;
    logic [VAL_W-1:0]   upper_bound_reg;

    logic [NPOS-1:0]    vld_reg;
    logic [NPOS-1:0]    adv;

    logic [VAL_W-1:0]   val_reg [0:DBL_STAGES];
    logic               rng_reg [0:DBL_STAGES];
    logic [BCD_W-1:0]   bcd_reg [1:DBL_STAGES];
    logic [BCD_W-1:0]   bcd_next [1:DBL_STAGES];

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [DIGIT_W-1:0] chk_reg;
    logic [VAL_W-1:0]   sval_reg;
    logic               srng_reg;

    logic               rng_next;
    logic [DIGIT_W-1:0] exp_next;
    logic               ok_next;

    logic               in_range_reg;
    logic               is_valid_reg;
    logic [SUM_W-1:0]   weighted_sum_reg;
    logic [DIGIT_W-1:0] expected_digit_reg;
    logic [VAL_W-1:0]   accepted_isbn_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= LOWER_RESET;
            upper_bound_reg <= UPPER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOWER_BOUND: lower_bound_reg <= cfg_data;
                CFG_UPPER_BOUND: upper_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when empty or when its item moves on
    assign adv[NPOS-1] = !vld_reg[NPOS-1] || out_ready;
    for (genvar k = 0; k < NPOS - 1; k++)
    begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NPOS; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input stage: capture the value and its range flag
    assign rng_next = (isbn_value > lower_bound_reg) && (isbn_value < upper_bound_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            val_reg[0] <= isbn_value;
            rng_reg[0] <= rng_next;
        end
    end

    // Binary to BCD stages, most significant bits first
    for (genvar k = 1; k <= DBL_STAGES; k++)
    begin : g_dbl
        if (k == 1)
        begin : g_first
            isbn_dbl_step u_step (
                .bcd_in  ('0),
                .bits_in (val_reg[0][VAL_W-1 -: STEP_BITS]),
                .bcd_out (bcd_next[k])
            );
        end
        else
        begin : g_rest
            isbn_dbl_step u_step (
                .bcd_in  (bcd_reg[k-1]),
                .bits_in (val_reg[k-1][VAL_W-1-STEP_BITS*(k-1) -: STEP_BITS]),
                .bcd_out (bcd_next[k])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                bcd_reg[k] <= bcd_next[k];
                val_reg[k] <= val_reg[k-1];
                rng_reg[k] <= rng_reg[k-1];
            end
        end
    end

    // Weighted sum: digits just left of the check digit get weight three
    always_comb
    begin
        logic [5:0] odd_sum;
        logic [5:0] even_sum;
        odd_sum  = '0;
        even_sum = '0;
        for (int i = 1; i <= 12; i++)
        begin
            if (i % 2 == 1)
                odd_sum = odd_sum + 6'(bcd_reg[DBL_STAGES][4*i +: 4]);
            else
                even_sum = even_sum + 6'(bcd_reg[DBL_STAGES][4*i +: 4]);
        end
        sum_next = SUM_W'({odd_sum, 1'b0}) + SUM_W'(odd_sum) + SUM_W'(even_sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv[SUM_POS])
        begin
            sum_reg  <= sum_next;
            chk_reg  <= bcd_reg[DBL_STAGES][DIGIT_W-1:0];
            sval_reg <= val_reg[DBL_STAGES];
            srng_reg <= rng_reg[DBL_STAGES];
        end
    end

    // Output stage: expected digit and decision
    assign exp_next = check_digit(sum_reg);
    assign ok_next  = srng_reg && (chk_reg == exp_next);

    always_ff @(posedge clk)
    begin
        if (adv[OUT_POS])
        begin
            in_range_reg       <= srng_reg;
            is_valid_reg       <= ok_next;
            weighted_sum_reg   <= sum_reg;
            expected_digit_reg <= exp_next;
            accepted_isbn_reg  <= ok_next ? sval_reg : '0;
        end
    end

    assign out_valid      = vld_reg[OUT_POS];
    assign in_range       = in_range_reg;
    assign is_valid       = is_valid_reg;
    assign weighted_sum   = weighted_sum_reg;
    assign expected_digit = expected_digit_reg;
    assign accepted_isbn  = accepted_isbn_reg;

    // Checks
    a_valid_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!is_valid || in_range))
        else $error("is_valid without in_range");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_valid) |-> (accepted_isbn == '0))
        else $error("rejected item carries nonzero isbn");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (expected_digit <= 4'd9 && weighted_sum <= 8'd216))
        else $error("expected digit or sum out of range");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item not captured");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[SUM_POS] && !adv[OUT_POS]) |=> (vld_reg[SUM_POS] && $stable(sum_reg)))
        else $error("sum stage lost item during stall");

endmodule

/* tb/isbn13_check_digit_validator_test.sv */
// Self-checking testbench for isbn13_check_digit_validator: random and directed ISBN items,
// a built-in predictor of the range and check digit verdicts, and several bound settings.
// Depends on isbn_pkg and the isbn13_check_digit_validator RTL.
`timescale 1ns / 100ps

module isbn13_check_digit_validator_test;
    import isbn_pkg::*;

    localparam int          LONG_HOLD     = 200;       // receiver hold-off, cycles
    localparam int          END_SETTLE    = 20;        // quiet cycles after the last result
    localparam int unsigned RUN_LIMIT_NS  = 4_800_000; // run time limit, ns
    localparam int          MAX_REPORTS   = 10;
    localparam logic [VAL_W-1:0] ALL_ONES = '1;
    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        logic                 in_range;
        logic                 is_valid;
        logic [SUM_W-1:0]     weighted_sum;
        logic [DIGIT_W-1:0]   expected_digit;
        logic [VAL_W-1:0]     accepted_isbn;
    } verdict_t;

    // DUT signals
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [VAL_W-1:0]     isbn_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 in_range;
    logic                 is_valid;
    logic [SUM_W-1:0]     weighted_sum;
    logic [DIGIT_W-1:0]   expected_digit;
    logic [VAL_W-1:0]     accepted_isbn;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOWER_BOUND;
    logic [VAL_W-1:0]     cfg_data = '0;

    // Testbench state
    logic [VAL_W-1:0] isbn_queue[$];     // items waiting to be offered
    verdict_t         verdict_queue[$];  // verdicts predicted for accepted items
    logic [VAL_W-1:0] lo_bound = LOWER_RESET;
    logic [VAL_W-1:0] hi_bound = UPPER_RESET;
    logic             in_took = 1'b0;
    logic             calm = 1'b0;       // no idling on either side
    logic             hold_request = 1'b0;
    int               hold_cycles = 0;
    int               gap_left = 0;
    int               stall_left = 0;
    int               mismatch_count = 0;
    int               results_seen = 0;
    int               accepted_seen = 0;
    int               in_range_seen = 0;
    int               bound_settings = 1;

    isbn13_check_digit_validator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .isbn_value     (isbn_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .in_range       (in_range),
        .is_valid       (is_valid),
        .weighted_sum   (weighted_sum),
        .expected_digit (expected_digit),
        .accepted_isbn  (accepted_isbn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Verdict for one ISBN under the given bounds
    function automatic verdict_t isbn_verdict(input logic [VAL_W-1:0] v,
                                              input logic [VAL_W-1:0] lo,
                                              input logic [VAL_W-1:0] hi);
        verdict_t        r;
        longint unsigned rest;
        int unsigned     sum;
        int unsigned     chk;
        rest = 64'(v) / 10;
        sum  = 0;
        // weights 3,1,3,... starting just left of the check digit
        for (int k = 0; k < 12; k++)
        begin
            sum += int'(rest % 10) * ((k % 2 == 0) ? 3 : 1);
            rest = rest / 10;
        end
        chk              = (10 - sum % 10) % 10;
        r.in_range       = (v > lo) && (v < hi);
        r.is_valid       = r.in_range && (int'(64'(v) % 10) == chk);
        r.weighted_sum   = SUM_W'(sum);
        r.expected_digit = DIGIT_W'(chk);
        r.accepted_isbn  = r.is_valid ? v : '0;
        return r;
    endfunction

    // Append the matching check digit to a twelve-digit body
    function automatic logic [VAL_W-1:0] with_check(input longint unsigned body);
        verdict_t t;
        t = isbn_verdict(VAL_W'(body * 10), '0, '0);
        return VAL_W'(body * 10 + t.expected_digit);
    endfunction

    function automatic longint unsigned random_digits(input int n);
        longint unsigned acc;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc = acc * 10 + $urandom_range(0, 9);
        return acc;
    endfunction

    // Random mix: mostly well-formed ISBNs, some broken check digits, bound edges and noise
    task automatic queue_random(input int n);
        int               pick;
        int               d;
        logic [63:0]      raw;
        logic [VAL_W-1:0] v;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                v = with_check(64'($urandom_range(978, 979)) * 64'd1_000_000_000
                               + random_digits(9));
            else if (pick < 60)
                v = with_check(random_digits(12));
            else if (pick < 72)
            begin
                v = with_check(64'($urandom_range(978, 979)) * 64'd1_000_000_000
                               + random_digits(9));
                d = int'(64'(v) % 10);
                v = v - VAL_W'(d) + VAL_W'((d + $urandom_range(1, 9)) % 10);
            end
            else if (pick < 82)
                v = ($urandom_range(0, 1) ? lo_bound : hi_bound)
                    + VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
            else if (pick < 91)
                v = VAL_W'(random_digits(13));
            else
            begin
                raw = {$urandom, $urandom};
                v   = raw[VAL_W-1:0];
            end
            isbn_queue.push_back(v);
        end
    endtask

    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item has been offered, accepted and answered
    task automatic drain();
        do
            @(posedge clk);
        while (isbn_queue.size() != 0 || in_valid || verdict_queue.size() != 0);
    endtask

    // Sender: offers queued items, with random gaps after acceptance
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_took)
        begin
            // item still waiting to be accepted
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (isbn_queue.size() != 0)
        begin
            in_valid   <= 1'b1;
            isbn_value <= isbn_queue.pop_front();
            if (!calm && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 12);
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request && hold_cycles < LONG_HOLD)
        begin
            out_ready <= 1'b0;
            hold_cycles++;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    // Monitor: predicts on accepted items, tracks bounds, checks results
    always @(posedge clk)
    begin
        verdict_t want;
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOWER_BOUND: lo_bound <= cfg_data;
                    CFG_UPPER_BOUND: hi_bound <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                verdict_queue.push_back(isbn_verdict(isbn_value, lo_bound, hi_bound));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (verdict_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: isbn=%0d valid=%0b", accepted_isbn,
                                 is_valid);
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    accepted_seen += want.is_valid;
                    in_range_seen += want.in_range;
                    if (in_range !== want.in_range || is_valid !== want.is_valid ||
                        weighted_sum !== want.weighted_sum ||
                        expected_digit !== want.expected_digit ||
                        accepted_isbn !== want.accepted_isbn)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected rng=%0b ok=%0b sum=%0d dig=%0d isbn=%0d",
                                     want.in_range, want.is_valid, want.weighted_sum,
                                     want.expected_digit, want.accepted_isbn,
                                     "\n          actual rng=%0b ok=%0b sum=%0d dig=%0d isbn=%0d",
                                     in_range, is_valid, weighted_sum, expected_digit,
                                     accepted_isbn);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("isbn13_check_digit_validator_test failed");
        $finish;
    end

    // Stimulus and phase control
    initial
    begin
        logic [VAL_W-1:0] win_lo;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset bounds
        isbn_queue.push_back('0);
        isbn_queue.push_back(ALL_ONES);
        isbn_queue.push_back(44'd9999999999999);
        isbn_queue.push_back(LOWER_RESET);
        isbn_queue.push_back(LOWER_RESET + 1);
        isbn_queue.push_back(UPPER_RESET);
        isbn_queue.push_back(UPPER_RESET - 1);
        isbn_queue.push_back(44'd9780306406157);
        isbn_queue.push_back(44'd9780306406158);
        isbn_queue.push_back(with_check(64'd979123456789));
        isbn_queue.push_back(with_check(64'd978000000000));
        isbn_queue.push_back(with_check(64'd979999999999));
        // more than thirteen digits: the upper digit only matters for range
        isbn_queue.push_back(44'd10000000000000 + with_check(64'd478030640615));
        drain();

        // Random items with reset bounds; the receiver holds off at the start
        hold_request = 1'b1;
        queue_random(400);
        drain();

        // Widest bounds
        write_bound(CFG_LOWER_BOUND, '0);
        write_bound(CFG_UPPER_BOUND, ALL_ONES);
        bound_settings++;
        // zero weighted sum, largest sum and values beyond thirteen digits
        isbn_queue.push_back('0);
        isbn_queue.push_back(44'd1);
        isbn_queue.push_back(44'd5);
        isbn_queue.push_back(44'd9);
        isbn_queue.push_back(44'd9999999999994);
        isbn_queue.push_back(ALL_ONES);
        isbn_queue.push_back(ALL_ONES - 1);
        isbn_queue.push_back(with_check(64'd699999999999) + 44'd10000000000000);
        queue_random(340);
        drain();

        // Equal bounds leave nothing in range; unmapped indexes must not touch them
        write_bound(CFG_LOWER_BOUND, 44'd9785000000000);
        write_bound(CFG_UPPER_BOUND, 44'd9785000000000);
        write_bound(CFG_UNMAPPED_A, 44'd1);
        write_bound(CFG_UNMAPPED_B, ALL_ONES);
        bound_settings++;
        queue_random(150);
        drain();

        // Narrow window around one well-formed ISBN
        win_lo = with_check(64'd978000000000 + random_digits(9)) - 3;
        write_bound(CFG_LOWER_BOUND, win_lo);
        write_bound(CFG_UPPER_BOUND, win_lo + 8);
        bound_settings++;
        queue_random(350);
        drain();

        // Inverted extremes
        write_bound(CFG_LOWER_BOUND, ALL_ONES);
        write_bound(CFG_UPPER_BOUND, '0);
        bound_settings++;
        queue_random(100);
        drain();

        // Reset values again, full rate on both sides
        write_bound(CFG_LOWER_BOUND, LOWER_RESET);
        write_bound(CFG_UPPER_BOUND, UPPER_RESET);
        bound_settings++;
        calm = 1'b1;
        queue_random(400);
        drain();

        repeat (END_SETTLE) @(posedge clk);
        $display("Checked %0d results (%0d in range, %0d accepted) over %0d bound settings.",
                 results_seen, in_range_seen, accepted_seen, bound_settings);
        if (mismatch_count == 0 && verdict_queue.size() == 0)
            $display("isbn13_check_digit_validator_test passed");
        else
            $display("isbn13_check_digit_validator_test failed");
        $finish;
    end

endmodule
